FILE: rtl/blpm_pkg.sv
// ----------------------------------------------------------------------------
// blpm_pkg
// Shared constants, codes and types of the bit-plane LED modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package blpm_pkg;

    localparam int NUM_LEDS = 16;
    localparam int MAX_BITS = 16;
    localparam int MIN_BITS = 2;

    localparam int IDX_W   = 4;
    localparam int DUTY_W  = 16;
    localparam int FRAME_W = 16;
    localparam int PLANE_W = 4;
    localparam int LSB_W   = 16;
    localparam int DEPTH_W = 5;
    // longest plane time is lsb_ticks shifted by the top plane index
    localparam int TICK_W  = LSB_W + (2 ** PLANE_W) - 1;

    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [LSB_W-1:0]   RESET_LSB_TICKS = LSB_W'(50);
    localparam logic [DEPTH_W-1:0] RESET_BIT_DEPTH = DEPTH_W'(8);

    // request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // register index, taken from paddr[ADDR_W-1]
    localparam logic REG_LSB_TICKS = 1'b0;
    localparam logic REG_BIT_DEPTH = 1'b1;

    // one request as it travels down the cell row
    typedef struct packed {
        logic               valid;
        logic               wr;
        logic [IDX_W-1:0]   idx;
        logic [DUTY_W-1:0]  duty;
        logic               res;
        logic [PLANE_W-1:0] plane;
        logic [FRAME_W-1:0] frame;
    } hop_t;

endpackage

`default_nettype wire

FILE: rtl/blpm_if.sv
// ----------------------------------------------------------------------------
// blpm_if
// Valid/ready channels of the modulator: request in, latched frame out.
// ----------------------------------------------------------------------------
`default_nettype none

interface blpm_in_if
    import blpm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               func;
    logic [IDX_W-1:0]   led_index;
    logic [DUTY_W-1:0]  duty;

    modport source (output valid, func, led_index, duty, input ready);
    modport sink   (input valid, func, led_index, duty, output ready);
endinterface

interface blpm_out_if
    import blpm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame;
    logic [PLANE_W-1:0] plane;

    modport source (output valid, frame, plane, input ready);
    modport sink   (input valid, frame, plane, output ready);
endinterface

`default_nettype wire

FILE: rtl/blpm_ctrl.sv
// ----------------------------------------------------------------------------
// blpm_ctrl
// Register file and plane timer: counts ticks down and picks the next plane.
// ----------------------------------------------------------------------------
`default_nettype none

module blpm_ctrl
    import blpm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output      logic [DATA_W-1:0]   prdata,
    input  wire logic                accept,
    input  wire logic                func,
    input  wire logic [IDX_W-1:0]    led_index,
    input  wire logic [DUTY_W-1:0]   duty,
    output      hop_t                entry
);

    logic [LSB_W-1:0]   lsb_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [PLANE_W-1:0] plane_reg;
    logic [TICK_W-1:0]  ticks_reg;

    logic [DEPTH_W-1:0] depth_use;
    logic [DEPTH_W-1:0] plane_inc;
    logic [PLANE_W-1:0] plane_next;
    logic [LSB_W-1:0]   lsb_eff;
    logic [TICK_W-1:0]  ticks_next;
    logic               expire;
    logic               cfg_wr;

    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        if (depth_reg < DEPTH_W'(MIN_BITS))
            depth_use = DEPTH_W'(MIN_BITS);
        else if (depth_reg > DEPTH_W'(MAX_BITS))
            depth_use = DEPTH_W'(MAX_BITS);
        else
            depth_use = depth_reg;
    end

    // plane left over from a larger depth also wraps to zero
    assign plane_inc  = DEPTH_W'(plane_reg) + DEPTH_W'(1);
    assign plane_next = (plane_inc >= depth_use) ? '0 : plane_inc[PLANE_W-1:0];
    assign lsb_eff    = (lsb_reg == '0) ? LSB_W'(1) : lsb_reg;
    assign ticks_next = TICK_W'(lsb_eff) << plane_next;
    assign expire     = (ticks_reg <= TICK_W'(1));

    always_comb
    begin
        unique case (paddr[ADDR_W-1])
            REG_LSB_TICKS: prdata = DATA_W'(lsb_reg);
            REG_BIT_DEPTH: prdata = DATA_W'(depth_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsb_reg   <= RESET_LSB_TICKS;
            depth_reg <= RESET_BIT_DEPTH;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[ADDR_W-1])
                REG_LSB_TICKS: lsb_reg   <= pwdata[LSB_W-1:0];
                REG_BIT_DEPTH: depth_reg <= pwdata[DEPTH_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
            ticks_reg <= TICK_W'(RESET_LSB_TICKS);
        end
        else if (accept && func == FUNC_TICK)
        begin
            if (expire)
            begin
                plane_reg <= plane_next;
                ticks_reg <= ticks_next;
            end
            else
            begin
                ticks_reg <= ticks_reg - TICK_W'(1);
            end
        end
    end

    // only duty writes and plane changes need to travel down the row
    always_comb
    begin
        entry.valid = accept && (func == FUNC_WRITE || expire);
        entry.wr    = (func == FUNC_WRITE);
        entry.idx   = led_index;
        entry.duty  = duty;
        entry.res   = (func == FUNC_TICK) && expire;
        entry.plane = plane_next;
        entry.frame = '0;
    end

endmodule

`default_nettype wire

FILE: rtl/blpm_cell.sv
// ----------------------------------------------------------------------------
// blpm_cell
// One LED: shadow and active duty, adds its bit to a passing frame.
// ----------------------------------------------------------------------------
`default_nettype none

module blpm_cell
    import blpm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic [IDX_W-1:0]   cell_id,
    input  wire hop_t               hop_in,
    output      hop_t               hop_out
);

    logic [DUTY_W-1:0]  shadow_reg;
    logic [DUTY_W-1:0]  active_reg;
    logic               hop_valid_reg;
    hop_t               hop_reg;
    hop_t               hop_next;

    logic               do_write;
    logic               do_copy;
    logic [DUTY_W-1:0]  shown_duty;

    assign do_write = hop_in.valid && hop_in.wr && (hop_in.idx == cell_id);
    assign do_copy  = hop_in.valid && hop_in.res && (hop_in.plane == '0);
    // on a copy the new frame already shows the shadow value
    assign shown_duty = do_copy ? shadow_reg : active_reg;

    always_comb
    begin
        hop_next = hop_in;
        if (hop_in.res)
            hop_next.frame = hop_in.frame
                           | (FRAME_W'(shown_duty[hop_in.plane]) << cell_id);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg    <= '0;
            active_reg    <= '0;
            hop_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (do_write)
                shadow_reg <= hop_in.duty;
            if (do_copy)
                active_reg <= shadow_reg;
            hop_valid_reg <= hop_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            hop_reg <= hop_next;
    end

    always_comb
    begin
        hop_out       = hop_reg;
        hop_out.valid = hop_valid_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/bit_plane_led_modulator_top.sv
// ----------------------------------------------------------------------------
// bit_plane_led_modulator_top
// Binary code modulation driver for 16 LEDs built as a row of LED cells.
// ----------------------------------------------------------------------------
// Path: a plane change from a taken tick request passes one cell stage per
// LED in turn and then enters the output register.
// Throughput: one request per cycle; the whole row stalls only while a
// frame sits unaccepted in the output register.
// Reset: rst_n clears duty stores and plane, loads the timer with 50 and
// returns lsb_ticks to 50 and bit_depth to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_plane_led_modulator_top
    import blpm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    blpm_in_if.sink                  in_ch,
    blpm_out_if.source               out_ch,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output      logic [DATA_W-1:0]   prdata,
    output      logic                pready
);

    logic               advance;
    logic               accept;
    hop_t               entry;
    hop_t               hops [NUM_LEDS];
    hop_t               last;

    logic               out_valid_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic [PLANE_W-1:0] out_plane_reg;

    assign pready      = 1'b1;
    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;
    assign accept      = in_ch.valid && advance;

    blpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .accept    (accept),
        .func      (in_ch.func),
        .led_index (in_ch.led_index),
        .duty      (in_ch.duty),
        .entry     (entry)
    );

    for (genvar j = 0; j < NUM_LEDS; j++)
    begin : g_cell
        blpm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .cell_id (IDX_W'(j)),
            .hop_in  ((j == 0) ? entry : hops[(j == 0) ? 0 : j - 1]),
            .hop_out (hops[j])
        );
    end

    assign last = hops[NUM_LEDS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= last.valid && last.res;
    end

    always_ff @(posedge clk)
    begin
        if (advance && last.valid && last.res)
        begin
            out_frame_reg <= last.frame;
            out_plane_reg <= last.plane;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.frame = out_frame_reg;
    assign out_ch.plane = out_plane_reg;

endmodule

`default_nettype wire

FILE: rtl/blpm_checker.sv
// ----------------------------------------------------------------------------
// blpm_checker
// Port-level checks of the modulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module blpm_checker
    import blpm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_ready,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire logic [FRAME_W-1:0]  out_frame,
    input  wire logic [PLANE_W-1:0]  out_plane,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    input  wire logic [DATA_W-1:0]   prdata
);

    // a held frame stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_frame) && $stable(out_plane))
        else $error("frame changed while stalled");

    // the row takes requests exactly when the output side can move
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    a_lsb_rd: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && !paddr[ADDR_W-1])
            && !paddr[ADDR_W-1] |->
            prdata == DATA_W'($past(pwdata[LSB_W-1:0])))
        else $error("lsb_ticks readback mismatch");

    a_depth_rd: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && paddr[ADDR_W-1])
            && paddr[ADDR_W-1] |->
            prdata == DATA_W'($past(pwdata[DEPTH_W-1:0])))
        else $error("bit_depth readback mismatch");

endmodule

bind bit_plane_led_modulator_top blpm_checker u_blpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_frame (out_ch.frame),
    .out_plane (out_ch.plane),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

`default_nettype wire
